[hdl/gmb_pkg.sv]
package gmb_pkg;

    localparam int DEF_MAX_WIDTH  = 32;
    localparam int DEF_MAX_HEIGHT = 32;

    // field widths of the channels and the configuration port
    localparam int CMD_W     = 2;
    localparam int POS_W     = 5;
    localparam int PICK_W    = 8;
    localparam int CELL_W    = 5;
    localparam int VTOT_W    = 11;
    localparam int CFG_W     = 6;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;

    localparam logic [CFG_W-1:0] RST_GRID_DIM = 6'd32;

    localparam int BIT_VISITED = 0;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_S = 2'd1,
        DIR_E = 2'd2,
        DIR_W = 2'd3
    } dir_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SEED,
        ST_NBR,
        ST_CUR,
        ST_EVAL,
        ST_PUSH,
        ST_POP,
        ST_CELL,
        ST_RESP
    } state_t;

endpackage

[hdl/gmb_if.sv]
interface gmb_req_if;
    logic                         valid;
    logic                         ready;
    logic [gmb_pkg::CMD_W-1:0]    command;
    logic [gmb_pkg::POS_W-1:0]    pos_x;
    logic [gmb_pkg::POS_W-1:0]    pos_y;
    logic [gmb_pkg::PICK_W-1:0]   pick;

    modport source (output valid, output command, output pos_x, output pos_y, output pick,
                    input ready);
    modport sink   (input valid, input command, input pos_x, input pos_y, input pick,
                    output ready);
endinterface

interface gmb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [gmb_pkg::POS_W-1:0]    top_x;
    logic [gmb_pkg::POS_W-1:0]    top_y;
    logic                         stack_empty;
    logic                         carved;
    logic [1:0]                   carved_dir;
    logic [gmb_pkg::CELL_W-1:0]   cell_bits;
    logic [gmb_pkg::VTOT_W-1:0]   visited_total;
    logic                         done_res;
    logic                         rejected;

    modport source (output valid, output top_x, output top_y, output stack_empty,
                    output carved, output carved_dir, output cell_bits,
                    output visited_total, output done_res, output rejected,
                    input ready);
    modport sink   (input valid, input top_x, input top_y, input stack_empty,
                    input carved, input carved_dir, input cell_bits,
                    input visited_total, input done_res, input rejected,
                    output ready);
endinterface

[hdl/grid_maze_backtracker.sv]
// Depth-first maze carver. The grid (visited and four path bits per cell) sits in a
// single-port memory of MAX_WIDTH*MAX_HEIGHT entries and the carve path in a stack memory
// of the same depth; the stack top is also held in registers. Each request returns one
// response. A carve step runs a neighbor read for each of the four directions (skipped
// off the grid), one read of the current cell, a decision step that writes the current
// cell (or reads the stack on a pop), a push step that writes the new cell and the stack
// entry, and a step to load the response register; the single grid port serializes them.
// A read request reads the cell, latches its bits and loads the response register. A
// start request inside the grid sweeps the whole grid to zero, one entry per cycle; the
// same sweep runs once after reset (no request taken meanwhile, configuration writes
// still accepted). The response register lets the next request in while a result waits.
// Width and height registers lie at byte addresses 0 and 4; they read back as written,
// but in use zero counts as one and values above the maximum saturate.
module grid_maze_backtracker #(
    parameter int MAX_WIDTH  = gmb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gmb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    gmb_req_if.sink                       req,
    gmb_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gmb_pkg::PADDR_W-1:0]   paddr,
    input  logic [gmb_pkg::PDATA_W-1:0]   pwdata,
    output logic [gmb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int EWX   = $clog2(MAX_WIDTH + 1);
    localparam int EWY   = $clog2(MAX_HEIGHT + 1);
    localparam int TW    = EWX + EWY;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int SW    = XW + YW;
    localparam int KW    = XW + YW + 8;
    localparam int CELL_W = gmb_pkg::CELL_W;
    localparam int POS_W  = gmb_pkg::POS_W;

    // ---------------- configuration ----------------
    logic [gmb_pkg::CFG_W-1:0] gw_reg;
    logic [gmb_pkg::CFG_W-1:0] gh_reg;
    logic                      cfg_wr;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= gmb_pkg::RST_GRID_DIM;
            gh_reg <= gmb_pkg::RST_GRID_DIM;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                gmb_pkg::REG_GRID_WIDTH:  gw_reg <= pwdata[gmb_pkg::CFG_W-1:0];
                gmb_pkg::REG_GRID_HEIGHT: gh_reg <= pwdata[gmb_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == gmb_pkg::REG_GRID_HEIGHT) ? gmb_pkg::PDATA_W'(gh_reg)
                                                           : gmb_pkg::PDATA_W'(gw_reg);

    logic [EWX-1:0] w_eff;
    logic [EWY-1:0] h_eff;
    logic [TW-1:0]  total;

    always_comb
    begin
        if (gw_reg == '0)
            w_eff = EWX'(1);
        else if (KW'(gw_reg) > KW'(MAX_WIDTH))
            w_eff = EWX'(MAX_WIDTH);
        else
            w_eff = EWX'(gw_reg);

        if (gh_reg == '0)
            h_eff = EWY'(1);
        else if (KW'(gh_reg) > KW'(MAX_HEIGHT))
            h_eff = EWY'(MAX_HEIGHT);
        else
            h_eff = EWY'(gh_reg);

        total = TW'(w_eff) * TW'(h_eff);
    end

    // ---------------- helpers ----------------
    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
        return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    function automatic logic [CELL_W-1:0] dir_mask(input gmb_pkg::dir_t d);
        return CELL_W'(2) << d;
    endfunction

    // pick mod n for n in 1..4; mod 3 folds base-4 digits (4 = 1 mod 3)
    function automatic logic [1:0] pick_mod(input logic [gmb_pkg::PICK_W-1:0] p,
                                            input logic [2:0] n);
        logic [3:0] s4;
        logic [2:0] s3;
        logic [2:0] t;
        logic [1:0] r;
        s4 = {2'b00, p[1:0]} + {2'b00, p[3:2]} + {2'b00, p[5:4]} + {2'b00, p[7:6]};
        s3 = {1'b0, s4[1:0]} + {1'b0, s4[3:2]};
        t  = {1'b0, s3[1:0]} + {2'b00, s3[2]};
        case (n)
            3'd1:    r = 2'd0;
            3'd2:    r = {1'b0, p[0]};
            3'd3:    r = (t == 3'd3) ? 2'd0 : t[1:0];
            default: r = p[1:0];
        endcase
        return r;
    endfunction

    // ---------------- state ----------------
    gmb_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    gmb_pkg::dir_t   nb_dir_reg, nb_dir_next;
    logic            rd_pend_reg, rd_pend_next;
    gmb_pkg::dir_t   rd_dir_reg, rd_dir_next;
    logic [3:0]      nb_vis_reg, nb_vis_next;
    logic [XW-1:0]   px_reg, px_next;
    logic [YW-1:0]   py_reg, py_next;
    logic [gmb_pkg::PICK_W-1:0] pick_reg, pick_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   visited_reg, visited_next;
    logic [XW-1:0]   top_x_reg, top_x_next;
    logic [YW-1:0]   top_y_reg, top_y_next;
    gmb_pkg::dir_t   sel_dir_reg, sel_dir_next;
    logic            carved_reg, carved_next;
    gmb_pkg::dir_t   cdir_reg, cdir_next;
    logic [CELL_W-1:0] bits_reg, bits_next;
    logic            rej_reg, rej_next;

    logic            out_valid_reg, out_valid_next;
    logic [POS_W-1:0] out_top_x_reg, out_top_x_next;
    logic [POS_W-1:0] out_top_y_reg, out_top_y_next;
    logic            out_empty_reg, out_empty_next;
    logic            out_carved_reg, out_carved_next;
    logic [1:0]      out_cdir_reg, out_cdir_next;
    logic [CELL_W-1:0] out_bits_reg, out_bits_next;
    logic [gmb_pkg::VTOT_W-1:0] out_vtot_reg, out_vtot_next;
    logic            out_done_reg, out_done_next;
    logic            out_rej_reg, out_rej_next;

    // ---------------- memories ----------------
    logic [CELL_W-1:0] grid_mem [CELLS];
    logic [CELL_W-1:0] grid_rdata_reg;
    logic              g_we, g_re;
    logic [AW-1:0]     g_addr;
    logic [CELL_W-1:0] g_wdata;

    always_ff @(posedge clk)
    begin
        if (g_we)
            grid_mem[g_addr] <= g_wdata;
        if (g_re)
            grid_rdata_reg <= grid_mem[g_addr];
    end

    logic [SW-1:0]     stack_mem [CELLS];
    logic [SW-1:0]     stack_rdata_reg;
    logic              s_we, s_re;
    logic [AW-1:0]     s_waddr, s_raddr;
    logic [SW-1:0]     s_wdata;

    always_ff @(posedge clk)
    begin
        if (s_we)
            stack_mem[s_waddr] <= s_wdata;
        if (s_re)
            stack_rdata_reg <= stack_mem[s_raddr];
    end

    // ---------------- neighbors of the stack top ----------------
    logic [XW-1:0] nb_x [4];
    logic [YW-1:0] nb_y [4];
    logic [3:0]    nb_in;
    logic [3:0]    cand;
    logic [2:0]    n_cand;
    logic [1:0]    k_sel;
    gmb_pkg::dir_t sel_dir;
    logic          x_ok, y_ok;

    always_comb
    begin
        x_ok = KW'(top_x_reg) < KW'(w_eff);
        y_ok = KW'(top_y_reg) < KW'(h_eff);

        nb_x[gmb_pkg::DIR_N] = top_x_reg;
        nb_y[gmb_pkg::DIR_N] = top_y_reg + YW'(1);
        nb_in[gmb_pkg::DIR_N] = x_ok && ((KW'(top_y_reg) + KW'(1)) < KW'(h_eff));

        nb_x[gmb_pkg::DIR_S] = top_x_reg;
        nb_y[gmb_pkg::DIR_S] = top_y_reg - YW'(1);
        nb_in[gmb_pkg::DIR_S] = x_ok && (top_y_reg != '0)
                                && (KW'(top_y_reg) < (KW'(h_eff) + KW'(1)));

        nb_x[gmb_pkg::DIR_E] = top_x_reg + XW'(1);
        nb_y[gmb_pkg::DIR_E] = top_y_reg;
        nb_in[gmb_pkg::DIR_E] = y_ok && ((KW'(top_x_reg) + KW'(1)) < KW'(w_eff));

        nb_x[gmb_pkg::DIR_W] = top_x_reg - XW'(1);
        nb_y[gmb_pkg::DIR_W] = top_y_reg;
        nb_in[gmb_pkg::DIR_W] = y_ok && (top_x_reg != '0)
                                && (KW'(top_x_reg) < (KW'(w_eff) + KW'(1)));
    end

    always_comb
    begin
        logic [2:0] cnt;
        cnt     = 3'd0;
        sel_dir = gmb_pkg::DIR_N;
        cand    = nb_in & ~nb_vis_reg;
        n_cand  = {2'b00, cand[0]} + {2'b00, cand[1]} + {2'b00, cand[2]} + {2'b00, cand[3]};
        k_sel   = pick_mod(pick_reg, n_cand);
        for (int d = 0; d < 4; d++)
        begin
            if (cand[d])
            begin
                if (cnt == {1'b0, k_sel})
                    sel_dir = gmb_pkg::dir_t'(d);
                cnt = cnt + 3'd1;
            end
        end
    end

    // ---------------- sequencer ----------------
    logic          done_now;
    logic          out_free;
    logic          pos_ok;
    logic [CW-1:0] cnt_m2;

    assign done_now = KW'(visited_reg) >= KW'(total);
    assign out_free = !out_valid_reg || rsp.ready;
    assign pos_ok   = (KW'(req.pos_x) < KW'(w_eff)) && (KW'(req.pos_y) < KW'(h_eff));
    assign cnt_m2   = count_reg - CW'(2);
    assign req.ready = (state_reg == gmb_pkg::ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        nb_dir_next  = nb_dir_reg;
        rd_pend_next = 1'b0;
        rd_dir_next  = rd_dir_reg;
        nb_vis_next  = nb_vis_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pick_next    = pick_reg;
        count_next   = count_reg;
        visited_next = visited_reg;
        top_x_next   = top_x_reg;
        top_y_next   = top_y_reg;
        sel_dir_next = sel_dir_reg;
        carved_next  = carved_reg;
        cdir_next    = cdir_reg;
        bits_next    = bits_reg;
        rej_next     = rej_reg;

        out_valid_next  = out_valid_reg;
        out_top_x_next  = out_top_x_reg;
        out_top_y_next  = out_top_y_reg;
        out_empty_next  = out_empty_reg;
        out_carved_next = out_carved_reg;
        out_cdir_next   = out_cdir_reg;
        out_bits_next   = out_bits_reg;
        out_vtot_next   = out_vtot_reg;
        out_done_next   = out_done_reg;
        out_rej_next    = out_rej_reg;

        g_we    = 1'b0;
        g_re    = 1'b0;
        g_addr  = cell_addr(top_x_reg, top_y_reg);
        g_wdata = '0;
        s_we    = 1'b0;
        s_re    = 1'b0;
        s_waddr = count_reg[AW-1:0];
        s_raddr = cnt_m2[AW-1:0];
        s_wdata = '0;

        if (rd_pend_reg)
            nb_vis_next[rd_dir_reg] = grid_rdata_reg[gmb_pkg::BIT_VISITED];

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            gmb_pkg::ST_INIT, gmb_pkg::ST_CLEAR:
            begin
                g_we     = 1'b1;
                g_addr   = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1))
                begin
                    clr_next   = '0;
                    state_next = (state_reg == gmb_pkg::ST_INIT) ? gmb_pkg::ST_IDLE
                                                                 : gmb_pkg::ST_SEED;
                end
            end

            gmb_pkg::ST_SEED:
            begin
                g_we         = 1'b1;
                g_addr       = cell_addr(px_reg, py_reg);
                g_wdata      = CELL_W'(1) << gmb_pkg::BIT_VISITED;
                s_we         = 1'b1;
                s_waddr      = '0;
                s_wdata      = {py_reg, px_reg};
                count_next   = CW'(1);
                visited_next = CW'(1);
                top_x_next   = px_reg;
                top_y_next   = py_reg;
                state_next   = gmb_pkg::ST_RESP;
            end

            gmb_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    px_next     = XW'(req.pos_x);
                    py_next     = YW'(req.pos_y);
                    pick_next   = req.pick;
                    carved_next = 1'b0;
                    cdir_next   = gmb_pkg::DIR_N;
                    bits_next   = '0;
                    rej_next    = 1'b0;
                    state_next  = gmb_pkg::ST_RESP;
                    case (req.command)
                        gmb_pkg::CMD_START:
                        begin
                            if (pos_ok)
                                state_next = gmb_pkg::ST_CLEAR;
                            else
                                rej_next = 1'b1;
                        end
                        gmb_pkg::CMD_STEP:
                        begin
                            if (count_reg == '0 || done_now)
                                rej_next = 1'b1;
                            else
                            begin
                                nb_dir_next = gmb_pkg::DIR_N;
                                state_next  = gmb_pkg::ST_NBR;
                            end
                        end
                        gmb_pkg::CMD_READ:
                        begin
                            if (pos_ok)
                            begin
                                g_re       = 1'b1;
                                g_addr     = cell_addr(XW'(req.pos_x), YW'(req.pos_y));
                                state_next = gmb_pkg::ST_CELL;
                            end
                            else
                                rej_next = 1'b1;
                        end
                        default: rej_next = 1'b1;
                    endcase
                end
            end

            gmb_pkg::ST_NBR:
            begin
                // skip the read for a neighbor off the grid; its bit is masked anyway
                if (nb_in[nb_dir_reg])
                begin
                    g_re         = 1'b1;
                    g_addr       = cell_addr(nb_x[nb_dir_reg], nb_y[nb_dir_reg]);
                    rd_pend_next = 1'b1;
                    rd_dir_next  = nb_dir_reg;
                end
                if (nb_dir_reg == gmb_pkg::DIR_W)
                    state_next = gmb_pkg::ST_CUR;
                else
                    nb_dir_next = gmb_pkg::dir_t'(nb_dir_reg + 2'd1);
            end

            gmb_pkg::ST_CUR:
            begin
                g_re       = 1'b1;
                g_addr     = cell_addr(top_x_reg, top_y_reg);
                state_next = gmb_pkg::ST_EVAL;
            end

            gmb_pkg::ST_EVAL:
            begin
                if (n_cand == 3'd0)
                begin
                    // dead end: pop and fetch the new top, or zero the top when the stack empties
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        top_x_next = '0;
                        top_y_next = '0;
                        state_next = gmb_pkg::ST_RESP;
                    end
                    else
                    begin
                        s_re       = 1'b1;
                        state_next = gmb_pkg::ST_POP;
                    end
                end
                else if (KW'(count_reg) >= KW'(CELLS))
                begin
                    rej_next   = 1'b1;
                    state_next = gmb_pkg::ST_RESP;
                end
                else
                begin
                    g_we         = 1'b1;
                    g_addr       = cell_addr(top_x_reg, top_y_reg);
                    g_wdata      = grid_rdata_reg | dir_mask(sel_dir);
                    sel_dir_next = sel_dir;
                    state_next   = gmb_pkg::ST_PUSH;
                end
            end

            gmb_pkg::ST_PUSH:
            begin
                g_we         = 1'b1;
                g_addr       = cell_addr(nb_x[sel_dir_reg], nb_y[sel_dir_reg]);
                g_wdata      = (CELL_W'(1) << gmb_pkg::BIT_VISITED)
                               | dir_mask(gmb_pkg::dir_t'(sel_dir_reg ^ 2'b01));
                s_we         = 1'b1;
                s_waddr      = count_reg[AW-1:0];
                s_wdata      = {nb_y[sel_dir_reg], nb_x[sel_dir_reg]};
                count_next   = count_reg + CW'(1);
                visited_next = visited_reg + CW'(1);
                top_x_next   = nb_x[sel_dir_reg];
                top_y_next   = nb_y[sel_dir_reg];
                carved_next  = 1'b1;
                cdir_next    = sel_dir_reg;
                state_next   = gmb_pkg::ST_RESP;
            end

            gmb_pkg::ST_POP:
            begin
                top_x_next = stack_rdata_reg[XW-1:0];
                top_y_next = stack_rdata_reg[SW-1:XW];
                state_next = gmb_pkg::ST_RESP;
            end

            gmb_pkg::ST_CELL:
            begin
                bits_next  = grid_rdata_reg;
                state_next = gmb_pkg::ST_RESP;
            end

            gmb_pkg::ST_RESP:
            begin
                // hold until the response register is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_top_x_next  = POS_W'(top_x_reg);
                    out_top_y_next  = POS_W'(top_y_reg);
                    out_empty_next  = (count_reg == '0);
                    out_carved_next = carved_reg;
                    out_cdir_next   = cdir_reg;
                    out_bits_next   = bits_reg;
                    out_vtot_next   = gmb_pkg::VTOT_W'(visited_reg);
                    out_done_next   = done_now;
                    out_rej_next    = rej_reg;
                    state_next      = gmb_pkg::ST_IDLE;
                end
            end

            default: state_next = gmb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gmb_pkg::ST_INIT;
            clr_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            count_reg     <= '0;
            visited_reg   <= '0;
            top_x_reg     <= '0;
            top_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rd_pend_reg   <= rd_pend_next;
            count_reg     <= count_next;
            visited_reg   <= visited_next;
            top_x_reg     <= top_x_next;
            top_y_reg     <= top_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nb_dir_reg     <= nb_dir_next;
        rd_dir_reg     <= rd_dir_next;
        nb_vis_reg     <= nb_vis_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        pick_reg       <= pick_next;
        sel_dir_reg    <= sel_dir_next;
        carved_reg     <= carved_next;
        cdir_reg       <= cdir_next;
        bits_reg       <= bits_next;
        rej_reg        <= rej_next;
        out_top_x_reg  <= out_top_x_next;
        out_top_y_reg  <= out_top_y_next;
        out_empty_reg  <= out_empty_next;
        out_carved_reg <= out_carved_next;
        out_cdir_reg   <= out_cdir_next;
        out_bits_reg   <= out_bits_next;
        out_vtot_reg   <= out_vtot_next;
        out_done_reg   <= out_done_next;
        out_rej_reg    <= out_rej_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.top_x         = out_top_x_reg;
    assign rsp.top_y         = out_top_y_reg;
    assign rsp.stack_empty   = out_empty_reg;
    assign rsp.carved        = out_carved_reg;
    assign rsp.carved_dir    = out_cdir_reg;
    assign rsp.cell_bits     = out_bits_reg;
    assign rsp.visited_total = out_vtot_reg;
    assign rsp.done_res      = out_done_reg;
    assign rsp.rejected      = out_rej_reg;

endmodule

[hdl/gmb_checker.sv]
module gmb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [gmb_pkg::POS_W-1:0]     top_x,
    input logic [gmb_pkg::POS_W-1:0]     top_y,
    input logic                          stack_empty,
    input logic                          carved,
    input logic [1:0]                    carved_dir,
    input logic [gmb_pkg::CELL_W-1:0]    cell_bits,
    input logic                          rejected
);

    // a response waiting for its taker stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // ready falls in the cycle after a request is taken
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken on two cycles in a row");

    // an empty stack reports the origin as its top
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && stack_empty |-> top_x == '0 && top_y == '0)
        else $error("empty stack with nonzero top");

    // a carve pushes a cell, never rejects, and only a carve names a direction
    a_carve: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (carved && !rejected && !stack_empty && cell_bits == '0)
                      || (!carved && carved_dir == 2'd0))
        else $error("inconsistent carve response");

endmodule

bind grid_maze_backtracker gmb_checker u_gmb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .top_x       (rsp.top_x),
    .top_y       (rsp.top_y),
    .stack_empty (rsp.stack_empty),
    .carved      (rsp.carved),
    .carved_dir  (rsp.carved_dir),
    .cell_bits   (rsp.cell_bits),
    .rejected    (rsp.rejected)
);
